[hdl/drd_pkg.sv]
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types, register codes and arithmetic helpers of the row decoder.
// ----------------------------------------------------------------------------
package drd_pkg;

   localparam int ELEMENT_WIDTH   = 32;
   localparam int COORD_WIDTH     = 16;
   localparam int OBJ_WIDTH       = 31;
   localparam int CLASS_WIDTH     = 8;
   localparam int THRESHOLD_WIDTH = 17;
   localparam int INDEX_WIDTH     = 9;
   localparam int CSR_ADDR_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH  = 17;

   localparam logic [THRESHOLD_WIDTH-1:0] CONF_THRESHOLD_RESET = 17'd32768;
   localparam logic [CLASS_WIDTH-1:0]     NUM_CLASSES_RESET    = 8'd80;

   // Position of each field within a row; class scores start at ROW_HEAD.
   localparam logic [INDEX_WIDTH-1:0] FIELD_CENTER_X  = 9'd0;
   localparam logic [INDEX_WIDTH-1:0] FIELD_CENTER_Y  = 9'd1;
   localparam logic [INDEX_WIDTH-1:0] FIELD_WIDTH     = 9'd2;
   localparam logic [INDEX_WIDTH-1:0] FIELD_HEIGHT    = 9'd3;
   localparam logic [INDEX_WIDTH-1:0] FIELD_OBJECT    = 9'd4;
   localparam logic [INDEX_WIDTH-1:0] ROW_HEAD        = 9'd5;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_CONF_THRESHOLD = 2'd0,
      CSR_NUM_CLASSES    = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] box_left;
      logic signed [COORD_WIDTH-1:0] box_top;
      logic signed [COORD_WIDTH-1:0] box_width;
      logic signed [COORD_WIDTH-1:0] box_height;
      logic [OBJ_WIDTH-1:0]          objectness;
      logic [CLASS_WIDTH-1:0]        class_id;
      logic                          class_found;
   } box_type;

   typedef struct packed {
      logic row_end;   // current element closes the row
      logic emit;      // and the row produces a box
   } row_status_type;

   // Q15.16 to integer, rounding toward zero.
   function automatic logic signed [COORD_WIDTH-1:0] trunc_q16(
      input logic signed [ELEMENT_WIDTH-1:0] q);
      logic signed [COORD_WIDTH-1:0] t;
      t = q[31:16];
      if (q[31] && (|q[15:0])) begin
         t = t + 16'sd1;
      end
      return t;
   endfunction

   // center - size/2 with the halving toward zero, saturated to 16 bits.
   function automatic logic signed [COORD_WIDTH-1:0] corner(
      input logic signed [COORD_WIDTH-1:0] center,
      input logic signed [COORD_WIDTH-1:0] size);
      logic signed [COORD_WIDTH:0]   half;
      logic signed [COORD_WIDTH+1:0] diff;
      logic signed [COORD_WIDTH-1:0] res;
      half = ($signed({size[15], size}) + $signed({16'b0, size[15]})) >>> 1;
      diff = $signed({{2{center[15]}}, center}) - $signed({half[16], half});
      if (diff > 18'sd32767) begin
         res = 16'sh7FFF;
      end else if (diff < -18'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = diff[15:0];
      end
      return res;
   endfunction

endpackage

[hdl/drd_req_if.sv]
// ----------------------------------------------------------------------------
// drd_req_if
// Element stream channel: one signed Q15.16 tensor element per transfer.
// ----------------------------------------------------------------------------
interface drd_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [drd_pkg::ELEMENT_WIDTH-1:0]    element_value;

   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

[hdl/drd_rsp_if.sv]
// ----------------------------------------------------------------------------
// drd_rsp_if
// Box result channel: one decoded detection per transfer.
// ----------------------------------------------------------------------------
interface drd_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [drd_pkg::COORD_WIDTH-1:0]   box_left;
   logic signed [drd_pkg::COORD_WIDTH-1:0]   box_top;
   logic signed [drd_pkg::COORD_WIDTH-1:0]   box_width;
   logic signed [drd_pkg::COORD_WIDTH-1:0]   box_height;
   logic [drd_pkg::OBJ_WIDTH-1:0]            objectness;
   logic [drd_pkg::CLASS_WIDTH-1:0]          class_id;
   logic                                     class_found;

   modport source (output valid, output box_left, output box_top, output box_width,
                   output box_height, output objectness, output class_id,
                   output class_found, input ready);
   modport sink   (input valid, input box_left, input box_top, input box_width,
                   input box_height, input objectness, input class_id,
                   input class_found, output ready);
endinterface

[hdl/drd_csr_if.sv]
// ----------------------------------------------------------------------------
// drd_csr_if
// Register write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface drd_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [drd_pkg::CSR_ADDR_WIDTH-1:0]    index;
   logic [drd_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/drd_row_decode.sv]
// ----------------------------------------------------------------------------
// drd_row_decode
// Row state: captures box fields, running class argmax, box assembly at row end.
// ----------------------------------------------------------------------------
module drd_row_decode (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  logic signed [drd_pkg::ELEMENT_WIDTH-1:0] element,
   input  logic [drd_pkg::CLASS_WIDTH-1:0]          num_classes,
   input  logic [drd_pkg::THRESHOLD_WIDTH-1:0]      conf_threshold,
   output drd_pkg::row_status_type                  status,
   output drd_pkg::box_type                         box
);

   logic [drd_pkg::INDEX_WIDTH-1:0]          idx_ff, idx_in;
   logic signed [drd_pkg::COORD_WIDTH-1:0]   cx_ff, cx_in;
   logic signed [drd_pkg::COORD_WIDTH-1:0]   cy_ff, cy_in;
   logic signed [drd_pkg::COORD_WIDTH-1:0]   w_ff, w_in;
   logic signed [drd_pkg::COORD_WIDTH-1:0]   h_ff, h_in;
   logic signed [drd_pkg::ELEMENT_WIDTH-1:0] obj_ff, obj_in;
   logic signed [drd_pkg::ELEMENT_WIDTH-1:0] best_ff, best_in;
   logic [drd_pkg::CLASS_WIDTH-1:0]          best_class_ff, best_class_in;
   logic                                     best_valid_ff, best_valid_in;

   logic [drd_pkg::INDEX_WIDTH-1:0]          last_idx;
   logic [drd_pkg::INDEX_WIDTH-1:0]          class_idx;
   logic                                     better;
   logic                                     row_end;

   // Row values as they stand after the current element is folded in.
   logic signed [drd_pkg::ELEMENT_WIDTH-1:0] cur_obj;
   logic [drd_pkg::CLASS_WIDTH-1:0]          cur_class;
   logic                                     cur_valid;

   assign last_idx  = (drd_pkg::FIELD_OBJECT) + {1'b0, num_classes};
   assign class_idx = idx_ff - drd_pkg::ROW_HEAD;
   assign better    = (idx_ff >= drd_pkg::ROW_HEAD) && (element > best_ff);
   assign row_end   = (idx_ff >= drd_pkg::FIELD_OBJECT) && (idx_ff >= last_idx);

   assign cur_obj   = (idx_ff == drd_pkg::FIELD_OBJECT) ? element : obj_ff;
   assign cur_class = better ? class_idx[drd_pkg::CLASS_WIDTH-1:0] : best_class_ff;
   assign cur_valid = better | best_valid_ff;

   // Signed objectness against the unsigned Q16 threshold, in 33 bits.
   assign status.row_end = row_end;
   assign status.emit    = row_end &&
      ($signed({cur_obj[31], cur_obj}) > $signed({16'b0, conf_threshold}));

   assign box.box_left    = drd_pkg::corner(cx_ff, w_ff);
   assign box.box_top     = drd_pkg::corner(cy_ff, h_ff);
   assign box.box_width   = w_ff;
   assign box.box_height  = h_ff;
   assign box.objectness  = cur_obj[drd_pkg::OBJ_WIDTH-1:0];
   assign box.class_id    = cur_valid ? cur_class : '0;
   assign box.class_found = cur_valid;

   always_comb begin
      idx_in        = idx_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      obj_in        = obj_ff;
      best_in       = best_ff;
      best_class_in = best_class_ff;
      best_valid_in = best_valid_ff;
      if (step) begin
         if (row_end) begin
            idx_in        = '0;
            cx_in         = '0;
            cy_in         = '0;
            w_in          = '0;
            h_in          = '0;
            obj_in        = '0;
            best_in       = '0;
            best_class_in = '0;
            best_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 9'd1;
            unique case (idx_ff)
               drd_pkg::FIELD_CENTER_X: cx_in  = drd_pkg::trunc_q16(element);
               drd_pkg::FIELD_CENTER_Y: cy_in  = drd_pkg::trunc_q16(element);
               drd_pkg::FIELD_WIDTH:    w_in   = drd_pkg::trunc_q16(element);
               drd_pkg::FIELD_HEIGHT:   h_in   = drd_pkg::trunc_q16(element);
               drd_pkg::FIELD_OBJECT:   obj_in = element;
               default: begin
                  if (better) begin
                     best_in       = element;
                     best_class_in = cur_class;
                     best_valid_in = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         w_ff          <= '0;
         h_ff          <= '0;
         obj_ff        <= '0;
         best_ff       <= '0;
         best_class_ff <= '0;
         best_valid_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         cx_ff         <= cx_in;
         cy_ff         <= cy_in;
         w_ff          <= w_in;
         h_ff          <= h_in;
         obj_ff        <= obj_in;
         best_ff       <= best_in;
         best_class_ff <= best_class_in;
         best_valid_ff <= best_valid_in;
      end
   end

endmodule

[hdl/detection_row_decoder_core.sv]
// ----------------------------------------------------------------------------
// detection_row_decoder_core
// Streams detector output elements and emits one box per row above threshold.
// ----------------------------------------------------------------------------
//  channel      dir  payload                                       per transfer
//  req_stream   in   element_value (Q15.16, signed 32)             one element
//  rsp_stream   out  box_left/top/width/height, objectness,        one box
//                    class_id, class_found
//  csr_write    in   index (0 conf_threshold, 1 num_classes), data one register
//
//  One element per cycle sustained unless a row-closing element stalls. An
//  element sits in the input register, then updates the row state; a
//  row-closing element writes the box register at that same edge, which
//  drives rsp_stream.valid. Only a row-closing element waits on a full box
//  register; all others pass regardless of rsp_stream.ready. Synchronous reset
//  clears the row state and both staging valid flags, and sets conf_threshold
//  to 0.5 and num_classes to 80.
// ----------------------------------------------------------------------------
module detection_row_decoder_core (
   input  logic       clock,
   input  logic       reset,
   drd_req_if.sink    req_stream,
   drd_rsp_if.source  rsp_stream,
   drd_csr_if.sink    csr_write
);

   // Configuration registers.
   logic [drd_pkg::THRESHOLD_WIDTH-1:0]      conf_threshold_ff, conf_threshold_in;
   logic [drd_pkg::CLASS_WIDTH-1:0]          num_classes_ff, num_classes_in;

   // Input register.
   logic                                     in_valid_ff, in_valid_in;
   logic signed [drd_pkg::ELEMENT_WIDTH-1:0] in_value_ff, in_value_in;

   // Box register.
   logic                                     rsp_valid_ff, rsp_valid_in;
   drd_pkg::box_type                         rsp_box_ff, rsp_box_in;

   drd_pkg::row_status_type                  status;
   drd_pkg::box_type                         row_box;
   logic                                     step;
   logic                                     req_xfer;
   logic                                     csr_xfer;

   // The held element advances unless it closes a row while the box register
   // is still occupied and not being drained this cycle.
   assign step     = in_valid_ff &&
                     (!status.row_end || !rsp_valid_ff || rsp_stream.ready);
   assign req_stream.ready = !in_valid_ff || step;
   assign req_xfer = req_stream.valid && req_stream.ready;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_write.ready = 1'b1;
   assign csr_xfer = csr_write.valid && csr_write.ready;

   drd_row_decode u_row (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .element        (in_value_ff),
      .num_classes    (num_classes_ff),
      .conf_threshold (conf_threshold_ff),
      .status         (status),
      .box            (row_box)
   );

   always_comb begin
      conf_threshold_in = conf_threshold_ff;
      num_classes_in    = num_classes_ff;
      if (csr_xfer) begin
         unique case (drd_pkg::csr_index_type'(csr_write.index))
            drd_pkg::CSR_CONF_THRESHOLD: conf_threshold_in = csr_write.data;
            drd_pkg::CSR_NUM_CLASSES:
               num_classes_in = csr_write.data[drd_pkg::CLASS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_value_in = in_value_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_value_in = req_stream.element_value;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // A new box may load in the same cycle the old one transfers out.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_box_in   = rsp_box_ff;
      if (step && status.emit) begin
         rsp_valid_in = 1'b1;
         rsp_box_in   = row_box;
      end else if (rsp_stream.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= drd_pkg::CONF_THRESHOLD_RESET;
         num_classes_ff    <= drd_pkg::NUM_CLASSES_RESET;
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         conf_threshold_ff <= conf_threshold_in;
         num_classes_ff    <= num_classes_in;
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_value_ff <= in_value_in;
      rsp_box_ff  <= rsp_box_in;
   end

   assign rsp_stream.valid       = rsp_valid_ff;
   assign rsp_stream.box_left    = rsp_box_ff.box_left;
   assign rsp_stream.box_top     = rsp_box_ff.box_top;
   assign rsp_stream.box_width   = rsp_box_ff.box_width;
   assign rsp_stream.box_height  = rsp_box_ff.box_height;
   assign rsp_stream.objectness  = rsp_box_ff.objectness;
   assign rsp_stream.class_id    = rsp_box_ff.class_id;
   assign rsp_stream.class_found = rsp_box_ff.class_found;

endmodule

[test/detection_row_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_row_decoder_core_tb
// Streams tensor rows into the row decoder and checks every box it returns.
// A behavioral copy of the decoder runs beside the block. It takes each element
// when the element is transferred and queues the box that the row should give.
// Directed rows cover the coordinate extremes, ties in the class argmax and a
// register change in the middle of a row. Random phases then vary both
// registers, the element gaps and the stalls on the box channel.
// ----------------------------------------------------------------------------
module detection_row_decoder_core_tb;

   localparam int RANDOM_ITEMS    = 620;
   localparam int BOX_LATENCY     = 1;
   localparam int SETTLE_CYCLES   = BOX_LATENCY + 4;
   localparam int DRAIN_GUARD     = 20000;
   localparam int WATCHDOG_CYCLES = 1000000;
   localparam int REPORT_LIMIT    = 10;

   logic clock;
   logic reset;

   drd_req_if req_if ();
   drd_rsp_if rsp_if ();
   drd_csr_if csr_if ();

   detection_row_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if),
      .csr_write  (csr_if)
   );

   // -------------------------------------------------------------------------
   // Decoder state kept by the testbench, updated on each element transfer
   // -------------------------------------------------------------------------
   logic [16:0]        cfg_threshold;
   logic [7:0]         cfg_classes;
   logic [8:0]         row_pos;
   logic signed [15:0] row_cx, row_cy, row_w, row_h;
   logic signed [31:0] row_obj;
   logic signed [31:0] top_score;
   logic [7:0]         top_class;
   logic               top_found;

   drd_pkg::box_type pending_boxes[$];     // boxes predicted but not yet transferred

   int elements_sent;
   int boxes_seen;
   int mismatch_count;
   int register_writes;

   // Sender burst / gap control and receiver stall control
   int gap_max;
   int burst_left;
   int stall_max;
   int stall_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the whole run
   initial begin
      repeat (WATCHDOG_CYCLES) @(posedge clock);
      $display("Watchdog expired with %0d boxes outstanding", pending_boxes.size());
      $display("Simulation FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Arithmetic of the decoder
   // -------------------------------------------------------------------------

   // Q15.16 to whole pixels; signed division rounds toward zero
   function automatic logic signed [15:0] to_pixels(input logic signed [31:0] q);
      int whole;
      whole = q / 32'sd65536;
      return whole[15:0];
   endfunction

   function automatic logic signed [15:0] clamp_coord(input int x);
      if (x > 32767) return 16'sh7FFF;
      if (x < -32768) return 16'sh8000;
      return x[15:0];
   endfunction

   task automatic clear_row();
      row_pos   = '0;
      row_cx    = '0;
      row_cy    = '0;
      row_w     = '0;
      row_h     = '0;
      row_obj   = '0;
      top_score = '0;
      top_class = '0;
      top_found = 1'b0;
   endtask

   // Take one transferred element; queue a box when it closes a passing row
   task automatic decode_element(input logic signed [31:0] v);
      int               last_pos;
      drd_pkg::box_type want;
      last_pos = 4 + int'(cfg_classes);
      case (row_pos)
         drd_pkg::FIELD_CENTER_X: row_cx = to_pixels(v);
         drd_pkg::FIELD_CENTER_Y: row_cy = to_pixels(v);
         drd_pkg::FIELD_WIDTH:    row_w  = to_pixels(v);
         drd_pkg::FIELD_HEIGHT:   row_h  = to_pixels(v);
         drd_pkg::FIELD_OBJECT:   row_obj = v;
         default: begin
            // strictly greater: the first of equal scores keeps the class
            if (v > top_score) begin
               top_score = v;
               top_class = 8'(row_pos - drd_pkg::ROW_HEAD);
               top_found = 1'b1;
            end
         end
      endcase
      if (int'(row_pos) < last_pos) begin
         row_pos = row_pos + 9'd1;
      end else begin
         // signed objectness against the unsigned threshold
         if (longint'(row_obj) > longint'(cfg_threshold)) begin
            want.box_left    = clamp_coord(int'(row_cx) - int'(row_w) / 2);
            want.box_top     = clamp_coord(int'(row_cy) - int'(row_h) / 2);
            want.box_width   = row_w;
            want.box_height  = row_h;
            want.objectness  = row_obj[30:0];
            want.class_id    = top_found ? top_class : 8'd0;
            want.class_found = top_found;
            pending_boxes = {pending_boxes, want};
         end
         clear_row();
      end
   endtask

   // -------------------------------------------------------------------------
   // Element sender: bursts of random length separated by random gaps
   // -------------------------------------------------------------------------
   task automatic send_element(input logic signed [31:0] v);
      if (gap_max > 0 && burst_left == 0) begin
         repeat ($urandom_range(1, gap_max)) begin
            @(negedge clock);
            req_if.valid         = 1'b0;
            req_if.element_value = $urandom;
         end
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      req_if.valid         = 1'b1;
      req_if.element_value = v;
      do @(posedge clock); while (!req_if.ready);
      decode_element(v);
      elements_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   // Hold the element channel quiet until every predicted box has come back,
   // then give a row-closing element still inside the core time to settle.
   task automatic drain_boxes();
      int guard;
      @(negedge clock);
      req_if.valid = 1'b0;
      guard = 0;
      while (pending_boxes.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input drd_pkg::csr_index_type which,
                                 input logic [16:0] value);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = which;
      csr_if.data  = value;
      do @(posedge clock); while (!csr_if.ready);
      case (which)
         drd_pkg::CSR_CONF_THRESHOLD: cfg_threshold = value;
         drd_pkg::CSR_NUM_CLASSES:    cfg_classes   = value[7:0];
         default: ;
      endcase
      register_writes++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic set_registers(input logic [16:0] threshold, input logic [7:0] classes);
      write_register(drd_pkg::CSR_CONF_THRESHOLD, threshold);
      write_register(drd_pkg::CSR_NUM_CLASSES, {9'd0, classes});
   endtask

   // -------------------------------------------------------------------------
   // Box receiver: stalls of random length, none at all when stall_max is 0
   // -------------------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready = 1'b1;
            if (stall_max > 0 && $urandom_range(0, 3) == 0) begin
               stall_left = $urandom_range(1, stall_max);
            end
         end
      end
   end

   task automatic check_box();
      drd_pkg::box_type got;
      drd_pkg::box_type want;
      logic             bad;
      got.box_left    = rsp_if.box_left;
      got.box_top     = rsp_if.box_top;
      got.box_width   = rsp_if.box_width;
      got.box_height  = rsp_if.box_height;
      got.objectness  = rsp_if.objectness;
      got.class_id    = rsp_if.class_id;
      got.class_found = rsp_if.class_found;
      boxes_seen++;
      if (pending_boxes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: box with none predicted:", $realtime);
            $display("   got  left=%0d top=%0d w=%0d h=%0d obj=%0d cls=%0d found=%0b",
                     got.box_left, got.box_top, got.box_width, got.box_height,
                     got.objectness, got.class_id, got.class_found);
         end
      end else begin
         want = pending_boxes.pop_front();
         bad  = (got.box_left    !== want.box_left)   ||
                (got.box_top     !== want.box_top)    ||
                (got.box_width   !== want.box_width)  ||
                (got.box_height  !== want.box_height) ||
                (got.objectness  !== want.objectness) ||
                (got.class_id    !== want.class_id)   ||
                (got.class_found !== want.class_found);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: box %0d wrong", $realtime, boxes_seen);
               $display("   want left=%0d top=%0d w=%0d h=%0d obj=%0d cls=%0d found=%0b",
                        want.box_left, want.box_top, want.box_width, want.box_height,
                        want.objectness, want.class_id, want.class_found);
               $display("   got  left=%0d top=%0d w=%0d h=%0d obj=%0d cls=%0d found=%0b",
                        got.box_left, got.box_top, got.box_width, got.box_height,
                        got.objectness, got.class_id, got.class_found);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         check_box();
      end
   end

   // -------------------------------------------------------------------------
   // Element generators for random rows
   // -------------------------------------------------------------------------
   function automatic logic signed [31:0] coord_value();
      int px;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 6))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'shFFFF_FFFF;
               3: return 32'sh0000_0000;
               4: return 32'shFFFF_0000;
               5: return 32'sh7FFF_0000;
               default: return 32'sh8000_0001;
            endcase
         end
         default: begin
            // ordinary image coordinates, a few slightly negative
            px = int'($urandom_range(0, 700)) - 30;
            return 32'(px * 65536 + int'($urandom_range(0, 65535)));
         end
      endcase
   endfunction

   function automatic logic signed [31:0] object_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 32'(int'(cfg_threshold) + int'($urandom_range(1, 65536)));
      if (r < 8) return 32'($urandom_range(0, int'(cfg_threshold)));
      if (r == 8) return 32'(cfg_threshold);
      return $urandom;
   endfunction

   function automatic logic signed [31:0] score_value(input logic signed [31:0] prev);
      case ($urandom_range(0, 7))
         0: return 32'sd0;
         1: return -32'($urandom_range(1, 65536));
         2: return prev;                             // tie with the previous score
         3: return $urandom;
         default: return 32'($urandom_range(1, 65536));
      endcase
   endfunction

   // One row: mostly well formed, some pure noise, some cut short
   task automatic send_row();
      logic signed [31:0] prev;
      int                 kind;
      // finish any row that an earlier broken sequence left open
      while (row_pos != '0) send_element($urandom);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat (5 + int'(cfg_classes)) send_element($urandom);
      end else if (kind == 1) begin
         repeat ($urandom_range(1, 4 + int'(cfg_classes))) send_element($urandom);
      end else begin
         send_element(coord_value());
         send_element(coord_value());
         send_element(coord_value());
         send_element(coord_value());
         send_element(object_value());
         prev = 32'sd0;
         repeat (int'(cfg_classes)) begin
            prev = score_value(prev);
            send_element(prev);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset registers in place: a row starts under 80 classes, then the class
   // count drops below the current position and the next element closes it.
   // Objectness is one above the reset threshold.
   task automatic test_reset_registers_midrow();
      send_element(32'sh0064_8000);
      send_element(32'sh0032_0000);
      send_element(32'sh0014_0000);
      send_element(32'sh000A_0000);
      send_element(32'sd32769);
      send_element(32'sh0000_4000);
      drain_boxes();
      write_register(drd_pkg::CSR_NUM_CLASSES, 17'd1);
      send_element(32'sh0001_0000);   // past the new end, still scored as class 1
   endtask

   // Zero classes and threshold 0: saturated corners, negative fractions,
   // largest objectness, objectness equal to the threshold.
   task automatic test_coordinate_extremes();
      drain_boxes();
      set_registers(17'd0, 8'd0);
      send_element(32'sh7FFF_FFFF);
      send_element(32'sh8000_0000);
      send_element(32'sh8000_0000);
      send_element(32'sh7FFF_FFFF);
      send_element(32'sd1);
      send_element(32'shFFFF_FFFF);
      send_element(32'sh0001_8000);
      send_element(32'shFFFD_8000);
      send_element(32'sh0003_0000);
      send_element(32'sh7FFF_FFFF);
      send_element(32'sh8000_0001);
      send_element(32'sh7FFF_0000);
      send_element(32'sh0000_FFFF);
      send_element(32'shFFFF_0001);
      send_element(32'sd0);
   endtask

   // Top threshold; a zero score, a tie and the most negative score
   task automatic test_class_argmax();
      drain_boxes();
      set_registers(17'h1FFFF, 8'd4);
      send_element(32'sh0140_0000);
      send_element(32'sh00F0_0000);
      send_element(32'sh0021_0000);
      send_element(32'sh0013_0000);
      send_element(32'sd131072);
      send_element(32'sd0);
      send_element(32'sh0000_0100);
      send_element(32'sh0000_0100);
      send_element(32'sh8000_0000);
   endtask

   // Random phases, each with its own registers, gaps and stalls
   task automatic test_random_rows();
      int          first_items;
      int          phase;
      int          rows;
      int          pick;
      logic [16:0] threshold;
      logic [7:0]  classes;
      first_items = elements_sent;
      phase = 0;
      while (elements_sent - first_items < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               threshold = drd_pkg::CONF_THRESHOLD_RESET;
               classes   = drd_pkg::NUM_CLASSES_RESET;
            end
            1: begin
               threshold = 17'h1FFFF;
               classes   = 8'd255;
            end
            2: begin
               threshold = 17'd0;
               classes   = 8'd0;
            end
            default: begin
               pick = $urandom_range(0, 9);
               if (pick == 0) threshold = 17'd0;
               else if (pick == 1) threshold = 17'h1FFFF;
               else if (pick == 2) threshold = 17'd65536;
               else threshold = 17'($urandom_range(0, 131071));
               pick = $urandom_range(0, 9);
               if (pick == 0) classes = 8'd0;
               else if (pick == 1) classes = 8'($urandom_range(9, 40));
               else classes = 8'($urandom_range(1, 8));
            end
         endcase
         drain_boxes();      // sender waits here for every outstanding box
         set_registers(threshold, classes);
         pick = $urandom_range(0, 2);
         gap_max   = (pick == 0) ? 0 : (pick == 1) ? 2 : 6;
         pick = $urandom_range(0, 2);
         stall_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 15;
         burst_left = 0;
         rows = 1 + 60 / (5 + int'(classes));
         repeat (rows) send_row();
         phase++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.element_value = '0;
      csr_if.valid         = 1'b0;
      csr_if.index         = drd_pkg::CSR_CONF_THRESHOLD;
      csr_if.data          = '0;
      cfg_threshold        = drd_pkg::CONF_THRESHOLD_RESET;
      cfg_classes          = drd_pkg::NUM_CLASSES_RESET;
      clear_row();
      elements_sent   = 0;
      boxes_seen      = 0;
      mismatch_count  = 0;
      register_writes = 0;
      gap_max         = 3;
      burst_left      = 0;
      stall_max       = 4;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_registers_midrow();
      test_coordinate_extremes();
      test_class_argmax();
      test_random_rows();

      drain_boxes();
      if (pending_boxes.size() != 0) begin
         $display("%0d predicted boxes never transferred", pending_boxes.size());
         mismatch_count += pending_boxes.size();
      end

      $display("Run covered %0d elements and %0d boxes over %0d register writes",
               elements_sent, boxes_seen, register_writes);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
